// ----- src/fdrs_pkg.sv -----
// Package with shared constants and types for the directory record search core.
package fdrs_pkg;

	localparam int RECORD_BYTES = 32;
	localparam int POS_W        = $clog2(RECORD_BYTES);
	localparam int NAME_LEN     = 11;

	localparam logic [7:0] MARK_UNUSED = 8'hE5;
	localparam logic [7:0] MARK_END    = 8'h00;
	localparam logic [3:0] LFN_NIBBLE  = 4'hF;
	localparam int         DIR_BIT     = 4;

	localparam logic [POS_W-1:0] OFS_FIRST  = POS_W'(0);
	localparam logic [POS_W-1:0] OFS_ATTR   = POS_W'(8'h0B);
	localparam logic [POS_W-1:0] OFS_CL_HI  = POS_W'(8'h14);
	localparam logic [POS_W-1:0] OFS_CL_LO  = POS_W'(8'h1A);
	localparam logic [POS_W-1:0] OFS_SIZE   = POS_W'(8'h1C);
	localparam logic [POS_W-1:0] OFS_LAST   = POS_W'(RECORD_BYTES - 1);
	localparam logic [POS_W-1:0] OFS_NAME_N = POS_W'(NAME_LEN);

	localparam logic       REG_NAME_BASE = 1'b0;
	localparam logic       REG_NAME_EXT  = 1'b1;
	localparam int         CFG_DATA_W    = 64;

	localparam logic [63:0] NAME_BASE_RST = 64'h2020202020202020;
	localparam logic [23:0] NAME_EXT_RST  = 24'h202020;

	localparam logic STATUS_FOUND = 1'b0;
	localparam logic STATUS_END   = 1'b1;

	typedef struct packed {
		logic        valid;
		logic        search_status;
		logic [31:0] start_cluster;
		logic [31:0] entry_size;
		logic        is_directory;
	} result_t;

endpackage

// ----- src/fat_directory_record_search_core.sv -----
// Top level of the FAT32 directory record search core.
// A result is registered in the output register, or in the skid slot while the output is stalled.
// Throughput: one byte per cycle while in_ready is high; the record parser updates its scan
// state in the cycle a byte transfers. in_ready drops only while both result slots are full.
// Reset: arst_n clears the scan state (next byte is byte 0 of a record), empties
// the result slots and loads the name registers with spaces.
module fat_directory_record_search_core import fdrs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  start_scan,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  search_status,
	output logic [31:0]           start_cluster,
	output logic [31:0]           entry_size,
	output logic                  is_directory
);

	result_t result;
	logic    accept;

	assign accept = in_valid && in_ready;

	fdrs_record_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.data_byte  (data_byte),
		.start_scan (start_scan),
		.result     (result)
	);

	fdrs_result_buffer u_buffer (
		.clk           (clk),
		.arst_n        (arst_n),
		.result        (result),
		.room          (in_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.search_status (search_status),
		.start_cluster (start_cluster),
		.entry_size    (entry_size),
		.is_directory  (is_directory)
	);

endmodule

// ----- src/fdrs_record_parser.sv -----
// Record parser: name registers, per-record capture state and result decision.
module fdrs_record_parser import fdrs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic [7:0]            data_byte,
	input  logic                  start_scan,
	output result_t               result
);

	logic [63:0]      name_base_q;
	logic [23:0]      name_ext_q;
	logic [POS_W-1:0] pos_q;
	logic             match_q;
	logic             skip_q;
	logic [7:0]       attr_q;
	logic [15:0]      cl_hi_q;
	logic [15:0]      cl_lo_q;
	logic [31:0]      size_q;
	logic             fin_q;

	logic [POS_W-1:0] pos_c;
	logic             match_c;
	logic             skip_c;
	logic [7:0]       attr_c;
	logic [15:0]      cl_hi_c;
	logic [15:0]      cl_lo_c;
	logic [31:0]      size_c;
	logic             fin_c;

	logic [POS_W-1:0] pos_n;
	logic             match_n;
	logic             skip_n;
	logic [7:0]       attr_n;
	logic [15:0]      cl_hi_n;
	logic [15:0]      cl_lo_n;
	logic [31:0]      size_n;
	logic             fin_n;

	logic [127:0]     name_w;
	logic [7:0]       tchar;
	logic             hit;

	assign name_w = {40'b0, name_ext_q, name_base_q};
	assign tchar  = name_w[{pos_c[3:0], 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_base_q <= NAME_BASE_RST;
			name_ext_q  <= NAME_EXT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NAME_BASE: name_base_q <= cfg_data;
				REG_NAME_EXT:  name_ext_q  <= cfg_data[23:0];
				default:       name_base_q <= name_base_q;
			endcase
		end
	end

	always_comb begin
		pos_c   = start_scan ? '0     : pos_q;
		match_c = start_scan ? 1'b1   : match_q;
		skip_c  = start_scan ? 1'b0   : skip_q;
		attr_c  = start_scan ? '0     : attr_q;
		cl_hi_c = start_scan ? '0     : cl_hi_q;
		cl_lo_c = start_scan ? '0     : cl_lo_q;
		size_c  = start_scan ? '0     : size_q;
		fin_c   = start_scan ? 1'b0   : fin_q;

		pos_n   = pos_c;
		match_n = match_c;
		skip_n  = skip_c;
		attr_n  = attr_c;
		cl_hi_n = cl_hi_c;
		cl_lo_n = cl_lo_c;
		size_n  = size_c;
		fin_n   = fin_c;
		hit     = 1'b0;

		result               = '0;
		result.search_status = STATUS_FOUND;

		if (!fin_c) begin
			if (pos_c == OFS_FIRST && data_byte == MARK_END) begin
				result.valid         = 1'b1;
				result.search_status = STATUS_END;
				pos_n   = '0;
				match_n = 1'b1;
				skip_n  = 1'b0;
				attr_n  = '0;
				cl_hi_n = '0;
				cl_lo_n = '0;
				size_n  = '0;
				fin_n   = 1'b1;
			end else begin
				if (pos_c == OFS_FIRST && data_byte == MARK_UNUSED)
					skip_n = 1'b1;
				if (pos_c < OFS_NAME_N && data_byte != tchar)
					match_n = 1'b0;
				if (pos_c == OFS_ATTR) begin
					attr_n = data_byte;
					if (data_byte[3:0] == LFN_NIBBLE)
						skip_n = 1'b1;
				end
				if (pos_c == OFS_CL_HI)
					cl_hi_n[7:0] = data_byte;
				if (pos_c == OFS_CL_HI + POS_W'(1))
					cl_hi_n[15:8] = data_byte;
				if (pos_c == OFS_CL_LO)
					cl_lo_n[7:0] = data_byte;
				if (pos_c == OFS_CL_LO + POS_W'(1))
					cl_lo_n[15:8] = data_byte;
				if (pos_c == OFS_SIZE)
					size_n[7:0] = data_byte;
				if (pos_c == OFS_SIZE + POS_W'(1))
					size_n[15:8] = data_byte;
				if (pos_c == OFS_SIZE + POS_W'(2))
					size_n[23:16] = data_byte;
				if (pos_c == OFS_LAST)
					size_n[31:24] = data_byte;

				if (pos_c == OFS_LAST) begin
					hit = match_n && !skip_n;
					result.valid         = hit;
					result.start_cluster = {cl_hi_n, cl_lo_n};
					result.entry_size    = size_n;
					result.is_directory  = attr_n[DIR_BIT];
					pos_n   = '0;
					match_n = 1'b1;
					skip_n  = 1'b0;
					attr_n  = '0;
					cl_hi_n = '0;
					cl_lo_n = '0;
					size_n  = '0;
					fin_n   = hit;
				end else begin
					pos_n = pos_c + POS_W'(1);
				end
			end
		end

		if (!accept)
			result.valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			match_q <= 1'b1;
			skip_q  <= 1'b0;
			attr_q  <= '0;
			cl_hi_q <= '0;
			cl_lo_q <= '0;
			size_q  <= '0;
			fin_q   <= 1'b0;
		end else if (accept) begin
			pos_q   <= pos_n;
			match_q <= match_n;
			skip_q  <= skip_n;
			attr_q  <= attr_n;
			cl_hi_q <= cl_hi_n;
			cl_lo_q <= cl_lo_n;
			size_q  <= size_n;
			fin_q   <= fin_n;
		end
	end

endmodule

// ----- src/fdrs_result_buffer.sv -----
// Result register with skid stage for the output channel.
module fdrs_result_buffer import fdrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  result_t     result,
	output logic        room,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        search_status,
	output logic [31:0] start_cluster,
	output logic [31:0] entry_size,
	output logic        is_directory
);

	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop  = out_q.valid && out_ready;
	assign room = !skid_q.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q  <= '0;
			skid_q <= '0;
		end else begin
			if (!out_q.valid) begin
				out_q <= result;
			end else if (pop) begin
				if (skid_q.valid) begin
					out_q  <= skid_q;
					skid_q <= result;
				end else begin
					out_q <= result;
				end
			end else if (result.valid) begin
				skid_q <= result;
			end
		end
	end

	assign out_valid     = out_q.valid;
	assign search_status = out_q.search_status;
	assign start_cluster = out_q.start_cluster;
	assign entry_size    = out_q.entry_size;
	assign is_directory  = out_q.is_directory;

endmodule

// ----- src/fdrs_checker.sv -----
// Port-level checker for the directory record search core, with its bind.
module fdrs_checker import fdrs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  data_byte,
	input logic        start_scan,
	input logic        out_valid,
	input logic        out_ready,
	input logic        search_status,
	input logic [31:0] start_cluster,
	input logic [31:0] entry_size,
	input logic        is_directory
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(search_status)
			&& $stable(start_cluster) && $stable(entry_size) && $stable(is_directory))
		else $error("stalled result changed");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && search_status == STATUS_END |->
			start_cluster == 32'd0 && entry_size == 32'd0 && !is_directory)
		else $error("end-of-directory result has nonzero fields");

	a_end_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && start_scan && data_byte == MARK_END && !out_valid
			|=> out_valid && search_status == STATUS_END)
		else $error("missing end-of-directory result");

endmodule

bind fat_directory_record_search_core fdrs_checker u_fdrs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.data_byte     (data_byte),
	.start_scan    (start_scan),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.search_status (search_status),
	.start_cluster (start_cluster),
	.entry_size    (entry_size),
	.is_directory  (is_directory)
);
